@@ sv/crs_pkg.sv @@
// Shared types, constants and field arithmetic for the Cauchy RS parity encoder.
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

    localparam int MAX_PARITY_DEF = 32;
    localparam logic [8:0]  FIELD_POLY = 9'h11B;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;

    typedef struct packed {
        logic [15:0] data_word;
        logic        last_word;
    } in_t;

    typedef struct packed {
        logic [15:0] out_word;
        logic        is_crc;
        logic        last_out;
    } out_t;

    typedef struct packed {
        logic acc_en;
        logic shift_en;
        logic clear;
    } cell_ctl_t;

    typedef logic [7:0] gf_table_t [256];

    // Carry-less multiply reduced modulo the field polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] aa;
        logic [7:0] p;
        aa = {1'b0, a};
        p  = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ aa[7:0];
            end
            aa = {aa[7:0], 1'b0};
            if (aa[8])
            begin
                aa = aa ^ FIELD_POLY;
            end
        end
        return p;
    endfunction

    // Inverse as a^254; zero maps to zero.
    function automatic gf_table_t build_inv_table();
        gf_table_t  t;
        logic [7:0] res;
        logic [7:0] base;
        logic [7:0] e;
        for (int a = 0; a < 256; a++)
        begin
            res  = 8'd1;
            base = 8'(a);
            e    = 8'd254;
            for (int k = 0; k < 8; k++)
            begin
                if (e[0])
                begin
                    res = gf_mul(res, base);
                end
                base = gf_mul(base, base);
                e    = e >> 1;
            end
            t[a] = res;
        end
        return t;
    endfunction

    localparam gf_table_t GF_INV_TABLE = build_inv_table();

    // Reflected CRC-32 over two bytes, high byte first.
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [15:0] w);
        logic [31:0] c;
        c = crc ^ {24'd0, w[15:8]};
        for (int b = 0; b < 8; b++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        c = c ^ {24'd0, w[7:0]};
        for (int b = 0; b < 8; b++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/crs_cell.sv @@
// One parity row: accumulates coefficient times each byte lane and shifts toward the output.
`timescale 1ns / 1ps
`default_nettype none
module crs_cell #(
    parameter int ROW = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  crs_pkg::cell_ctl_t  ctl,
    input  wire  [15:0]         data_word,
    input  wire  [6:0]          col,
    input  wire  [15:0]         shift_in,
    output logic [15:0]         acc
);

    localparam logic [7:0] ROW_CODE = 8'(ROW);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [7:0]  coef;

    assign coef = crs_pkg::GF_INV_TABLE[ROW_CODE ^ {1'b1, col}];

    always_comb
    begin
        acc_next = acc_reg;
        priority if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.shift_en)
        begin
            acc_next = shift_in;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg ^ {crs_pkg::gf_mul(coef, data_word[15:8]),
                                  crs_pkg::gf_mul(coef, data_word[7:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ sv/cauchy_rs_parity_crc_encoder_core.sv @@
// Top level of the Cauchy RS parity encoder with CRC-32 trailer.
`timescale 1ns / 1ps
`default_nettype none
// For each data word taken in, every parity row cell multiplies both bytes by its
// Cauchy coefficient and folds the products into its row, and the CRC absorbs both bytes in
// the same cycle. After the last word of a block the cells act as a shift chain that moves
// one parity row per cycle into the output register, followed by the two CRC halves, so a
// block of W words gives n + 2 output words (n = effective parity count),
// one per cycle when the sink is ready. No word is taken while the block is draining.
module cauchy_rs_parity_crc_encoder_core #(
    parameter int MAX_PARITY = crs_pkg::MAX_PARITY_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  crs_pkg::in_t   in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output crs_pkg::out_t  out_data,
    input  wire            cfg_wr_en,
    input  wire  [5:0]     cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam logic [6:0] MAX7 = 7'(MAX_PARITY);

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_PAR,
        ST_CRC_HI,
        ST_CRC_LO
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [6:0]          col_reg, col_next;
    logic [31:0]         crc_reg, crc_next;
    logic [31:0]         crc_final_reg, crc_final_next;
    logic [5:0]          cfg_reg;
    logic                out_valid_reg, out_valid_next;
    crs_pkg::out_t       out_reg, out_next;
    crs_pkg::cell_ctl_t  ctl;
    logic                in_fire;
    logic                load_ok;
    logic [6:0]          eff_count;
    logic [15:0]         acc [MAX_PARITY];

    assign in_ready = (state_reg == ST_ACCEPT);
    assign in_fire  = in_valid && in_ready;
    assign load_ok  = !out_valid_reg || out_ready;

    // Zero means one row; anything above the build maximum saturates.
    always_comb
    begin
        priority if (cfg_reg == 6'd0)
        begin
            eff_count = 7'd1;
        end
        else if ({1'b0, cfg_reg} > MAX7)
        begin
            eff_count = MAX7;
        end
        else
        begin
            eff_count = {1'b0, cfg_reg};
        end
    end

    genvar r;
    generate
        for (r = 0; r < MAX_PARITY; r++)
        begin : g_cell
            logic [15:0] nbr;
            if (r == MAX_PARITY - 1)
            begin : g_tail
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = acc[r + 1];
            end
            crs_cell #(
                .ROW(r)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .data_word (in_data.data_word),
                .col       (col_reg),
                .shift_in  (nbr),
                .acc       (acc[r])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        crc_next       = crc_reg;
        crc_final_next = crc_final_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ctl            = '0;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (in_fire)
                begin
                    ctl.acc_en = 1'b1;
                    if (in_data.last_word)
                    begin
                        col_next       = '0;
                        crc_next       = crs_pkg::CRC_ONES;
                        crc_final_next = crs_pkg::crc_word(crc_reg, in_data.data_word)
                                         ^ crs_pkg::CRC_ONES;
                        cnt_next       = CNT_W'(eff_count);
                        state_next     = ST_PAR;
                    end
                    else
                    begin
                        col_next = col_reg + 7'd1;
                        crc_next = crs_pkg::crc_word(crc_reg, in_data.data_word);
                    end
                end
            end
            ST_PAR:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_word: acc[0], is_crc: 1'b0, last_out: 1'b0};
                    ctl.shift_en   = 1'b1;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_CRC_HI;
                    end
                end
            end
            ST_CRC_HI:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_word: crc_final_reg[31:16], is_crc: 1'b1,
                                       last_out: 1'b0};
                    // Rows beyond the emitted count still hold data; wipe them all.
                    ctl.clear      = 1'b1;
                    state_next     = ST_CRC_LO;
                end
            end
            ST_CRC_LO:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_word: crc_final_reg[15:0], is_crc: 1'b1,
                                       last_out: 1'b1};
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            crc_reg       <= crs_pkg::CRC_ONES;
            cfg_reg       <= 6'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_final_reg <= crc_final_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_last_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_out |-> out_data.is_crc)
        else $error("final word of a block is not a CRC half");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_word |=> !in_ready)
        else $error("input taken right after the last word of a block");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAR |-> cnt_reg != '0)
        else $error("parity drain running with a zero row count");

    a_crc_lo_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CRC_LO && load_ok |=> in_ready && out_valid && out_data.last_out)
        else $error("block did not finish after the CRC low half");

endmodule
`default_nettype wire

@@ dv/cauchy_rs_parity_crc_encoder_checker.sv @@
// Checker that predicts the encoder's parity and CRC result words and compares them.
`timescale 1ns / 1ps
module cauchy_rs_parity_crc_encoder_checker #(
    parameter int ROWS = crs_pkg::MAX_PARITY_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    input  wire            in_ready,
    input  crs_pkg::in_t   in_data,
    input  wire            out_valid,
    input  wire            out_ready,
    input  crs_pkg::out_t  out_data,
    input  wire            cfg_wr_en,
    input  wire  [5:0]     cfg_wr_data,
    output int             mismatch_count,
    output int             words_due
);

    localparam logic [7:0]  REDUCE_BITS   = 8'h1B;
    localparam logic [31:0] CRC_REFLECTED = 32'hEDB88320;

    logic [7:0]     inverse_lut [256];
    logic [15:0]    row_parity [ROWS];
    logic [6:0]     column;
    logic [31:0]    crc_run;
    logic [31:0]    crc_final;
    logic [5:0]     row_count_cfg;
    logic [7:0]     coef;
    logic [7:0]     hi_byte;
    logic [7:0]     lo_byte;
    crs_pkg::out_t  parity_crc_due [$];
    crs_pkg::out_t  due_word;
    crs_pkg::out_t  want;
    int             rows_out;
    int             errors;

    // Product in the byte field, Horner style from the top bit of a.
    function automatic logic [7:0] field_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 7; i >= 0; i--)
        begin
            p = {p[6:0], 1'b0} ^ (p[7] ? REDUCE_BITS : 8'h00);
            if (a[i])
            begin
                p = p ^ b;
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] crc_add_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_REFLECTED) : (r >> 1);
        end
        return r;
    endfunction

    // Inverses are found by search, so the table does not depend on any power chain.
    initial
    begin
        for (int a = 0; a < 256; a++)
        begin
            inverse_lut[a] = 8'h00;
            for (int b = 1; b < 256; b++)
            begin
                if (field_mult(8'(a), 8'(b)) == 8'h01)
                begin
                    inverse_lut[a] = 8'(b);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                row_parity[r] = '0;
            end
            column        = '0;
            crc_run       = '1;
            row_count_cfg = 6'd1;
            errors        = 0;
            parity_crc_due.delete();
            mismatch_count <= 0;
            words_due      <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                row_count_cfg = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                hi_byte = in_data.data_word[15:8];
                lo_byte = in_data.data_word[7:0];
                // Every row accumulates, whatever the count that is in force.
                for (int r = 0; r < ROWS; r++)
                begin
                    coef = inverse_lut[8'(r) ^ {1'b1, column}];
                    row_parity[r] = row_parity[r] ^
                                    {field_mult(coef, hi_byte), field_mult(coef, lo_byte)};
                end
                column  = column + 7'd1;
                crc_run = crc_add_byte(crc_add_byte(crc_run, hi_byte), lo_byte);
                if (in_data.last_word)
                begin
                    if (row_count_cfg == 6'd0)
                    begin
                        rows_out = 1;
                    end
                    else if (row_count_cfg > ROWS)
                    begin
                        rows_out = ROWS;
                    end
                    else
                    begin
                        rows_out = row_count_cfg;
                    end
                    for (int r = 0; r < rows_out; r++)
                    begin
                        due_word = '{out_word: row_parity[r], is_crc: 1'b0, last_out: 1'b0};
                        parity_crc_due = {parity_crc_due, due_word};
                    end
                    crc_final = ~crc_run;
                    due_word = '{out_word: crc_final[31:16], is_crc: 1'b1, last_out: 1'b0};
                    parity_crc_due = {parity_crc_due, due_word};
                    due_word = '{out_word: crc_final[15:0], is_crc: 1'b1, last_out: 1'b1};
                    parity_crc_due = {parity_crc_due, due_word};
                    for (int r = 0; r < ROWS; r++)
                    begin
                        row_parity[r] = '0;
                    end
                    column  = '0;
                    crc_run = '1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (parity_crc_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result word %h is_crc %b last_out %b",
                                 out_data.out_word, out_data.is_crc, out_data.last_out);
                    end
                end
                else
                begin
                    want = parity_crc_due.pop_front();
                    if (out_data.out_word !== want.out_word || out_data.is_crc !== want.is_crc
                        || out_data.last_out !== want.last_out)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.out_word, want.is_crc, want.last_out,
                                     out_data.out_word, out_data.is_crc, out_data.last_out);
                        end
                    end
                end
            end
            mismatch_count <= errors;
            words_due      <= parity_crc_due.size();
        end
    end

endmodule

@@ dv/cauchy_rs_parity_crc_encoder_core_tb.sv @@
// Testbench top for the Cauchy RS parity encoder: stimulus, sink stalls and verdict.
`timescale 1ns / 1ps
module cauchy_rs_parity_crc_encoder_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    logic           clk;
    logic           rst_n       = 1'b0;
    logic           in_valid    = 1'b0;
    crs_pkg::in_t   in_data     = '0;
    logic           out_ready   = 1'b0;
    logic           cfg_wr_en   = 1'b0;
    logic [5:0]     cfg_wr_data = '0;
    logic           hold_req    = 1'b0;
    logic           in_ready;
    logic           out_valid;
    crs_pkg::out_t  out_data;
    int             mismatch_count;
    int             words_due;
    int             burst_left  = 0;
    int             words_sent;
    int             blocks;
    int             block_len;
    int             rx_cycle    = 0;
    int             rx_mode     = 0;
    logic           hold_done   = 1'b0;
    int             idle_cycles = 0;

    cauchy_rs_parity_crc_encoder_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    cauchy_rs_parity_crc_encoder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Words go out in bursts; a gap drops valid only between two accepted words.
    task automatic send_word(input logic [15:0] w, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{data_word: w, last_word: last};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [5:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count still at its reset value.
        send_word(16'h0000, 1'b1);
        wait_drained();
        // A count of zero acts as one.
        write_count(6'd0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8001, 1'b1);
        wait_drained();
        write_count(6'd32);
        send_word(16'h00FF, 1'b0);
        send_word(16'hFF00, 1'b0);
        send_word(16'h1234, 1'b1);
        wait_drained();
        // Counts above the row total saturate.
        write_count(6'd63);
        send_word(16'hFFFF, 1'b1);
        wait_drained();
        write_count(6'd33);
        send_word(16'hA5A5, 1'b1);
        wait_drained();
        // The count in force at the last word decides how many rows come out.
        write_count(6'd2);
        send_word(16'h0102, 1'b0);
        send_word(16'h0304, 1'b0);
        wait_drained();
        write_count(6'd5);
        send_word(16'h0506, 1'b1);

        hold_req <= 1'b1;
        words_sent = 0;
        blocks     = 0;
        while (words_sent < 150)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                write_count(($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(1, 8)));
            end
            // One block runs past 128 words so that the column index wraps.
            block_len = (blocks == 4) ? $urandom_range(129, 140) : $urandom_range(1, 6);
            for (int i = 0; i < block_len; i++)
            begin
                send_word(16'($urandom), i == block_len - 1);
            end
            words_sent += block_len;
            blocks++;
        end
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Sink: a randomly chosen stall pattern, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            if (rx_cycle % 64 == 0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 5 != 0);
            endcase
            rx_cycle++;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
